[hdl/arp_pkg.sv]
// arp_pkg: shared types and codes for the ARP cache table.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [IP_W-1:0]    ip_addr_t;
    typedef logic [MAC_W-1:0]   mac_addr_t;
    typedef logic [COUNT_W-1:0] entry_count_t;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_MISS     = 2'd0,
        ST_HIT      = 2'd1,
        ST_UPDATED  = 2'd2,
        ST_INSERTED = 2'd3
    } status_t;

endpackage

`default_nettype wire

[hdl/arp_if.sv]
// arp_if: request and response channel interfaces for the ARP cache table.
// Depends on arp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface arp_req_if;
    logic               valid;
    logic               ready;
    arp_pkg::opcode_t   opcode;
    arp_pkg::ip_addr_t  ip_addr;
    arp_pkg::mac_addr_t new_mac;

    modport source (output valid, output opcode, output ip_addr, output new_mac, input ready);
    modport sink   (input valid, input opcode, input ip_addr, input new_mac, output ready);
endinterface

interface arp_rsp_if;
    logic                   valid;
    logic                   ready;
    arp_pkg::status_t       status;
    logic                   dropped;
    arp_pkg::mac_addr_t     found_mac;
    arp_pkg::entry_count_t  entry_count;

    modport source (output valid, output status, output dropped, output found_mac,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input dropped, input found_mac,
                    input entry_count, output ready);
endinterface

`default_nettype wire

[hdl/arp_cache_table.sv]
// arp_cache_table: IPv4-to-MAC table with lookup and insert/update.
// Pipeline: a request transfers into the input register, then into the result
// register, which drives the response; a stalled response holds both stages.
// Throughput: one operation per cycle while the response side keeps taking
// transfers.
// Reset clears the pipeline valids and the fill count; table contents are
// left as they are and only entries below the fill count are ever compared.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    arp_req_if.sink      req,
    arp_rsp_if.source    rsp
);
    import arp_pkg::*;

    // Index covers the entries; count must also hold TABLE_ENTRIES itself.
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // ------------------------------------------------------------------
    // Table storage: flops, searched in parallel (CAM style).
    // ------------------------------------------------------------------
    ip_addr_t   ip_store  [TABLE_ENTRIES];
    mac_addr_t  mac_store [TABLE_ENTRIES];
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    opcode_t    s1_opcode_reg;
    ip_addr_t   s1_ip_reg;
    mac_addr_t  s1_mac_reg;

    // Result register stage
    logic           out_valid_reg;
    status_t        status_reg,    status_next;
    logic           dropped_reg,   dropped_next;
    mac_addr_t      found_mac_reg, found_mac_next;
    entry_count_t   count_reg,     count_next;

    // Handshake: s1 moves on when the result register is free or emptying.
    logic s1_move;
    logic in_take;

    assign s1_move = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign in_take = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Parallel match over the filled entries; lowest index wins
    // (a duplicate cannot be appended, so at most one matches anyway).
    // ------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;
    logic                     full;
    logic [IDX_W-1:0]         append_idx;
    logic                     wr_update;
    logic                     wr_append;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    always_comb
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            match_vec[k] = (CNT_W'(k) < fill_count_reg) && (ip_store[k] == s1_ip_reg);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--)
        begin
            if (match_vec[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
    end

    assign hit        = |match_vec;
    assign full       = (fill_count_reg == CNT_W'(TABLE_ENTRIES));
    assign append_idx = fill_count_reg[IDX_W-1:0];

    // Decode the operation into table writes and the result fields.
    always_comb
    begin
        status_next     = ST_MISS;
        dropped_next    = 1'b0;
        found_mac_next  = '0;
        fill_count_next = fill_count_reg;
        wr_update       = 1'b0;
        wr_append       = 1'b0;

        case (s1_opcode_reg)
            OP_LOOKUP:
            begin
                if (hit)
                begin
                    status_next    = ST_HIT;
                    found_mac_next = mac_store[hit_idx];
                end
            end
            OP_INSERT:
            begin
                if (hit)
                begin
                    status_next = ST_UPDATED;
                    wr_update   = s1_move;
                end
                else if (!full)
                begin
                    status_next     = ST_INSERTED;
                    wr_append       = s1_move;
                    fill_count_next = fill_count_reg + CNT_W'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    // Count reported masked (or zero-extended) to the output width.
    assign count_ext  = {{COUNT_W{1'b0}}, fill_count_next};
    assign count_next = count_ext[COUNT_W-1:0];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fill_count_reg <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_move)
            begin
                out_valid_reg  <= 1'b1;
                fill_count_reg <= fill_count_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg <= req.opcode;
            s1_ip_reg     <= req.ip_addr;
            s1_mac_reg    <= req.new_mac;
        end
        if (s1_move)
        begin
            status_reg    <= status_next;
            dropped_reg   <= dropped_next;
            found_mac_reg <= found_mac_next;
            count_reg     <= count_next;
        end
    end

    // Table writes: update in place on a match, else append at the fill point unless full.
    always_ff @(posedge clk)
    begin
        if (wr_update)
        begin
            mac_store[hit_idx] <= s1_mac_reg;
        end
        if (wr_append)
        begin
            ip_store[append_idx]  <= s1_ip_reg;
            mac_store[append_idx] <= s1_mac_reg;
        end
    end

    // ------------------------------------------------------------------
    // Response channel
    // ------------------------------------------------------------------
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.dropped     = dropped_reg;
    assign rsp.found_mac   = found_mac_reg;
    assign rsp.entry_count = count_reg;

endmodule

`default_nettype wire
